### src/request_timeout_retry_tracker_macros.svh
// ----------------------------------------------------------------------------
// Request timeout retry tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_TIMEOUT_RETRY_TRACKER_MACROS_SVH
`define REQUEST_TIMEOUT_RETRY_TRACKER_MACROS_SVH

// Assert that a property holds at every clock edge outside reset.
`define RTRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that a condition never becomes true outside reset.
`define RTRT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/rtrt_pkg.sv
// ----------------------------------------------------------------------------
// Request timeout retry tracker package
// Operation and result codes, engine states and the item structures.
// ----------------------------------------------------------------------------
package rtrt_pkg;

    // Input mode codes.
    localparam logic [1:0] MODE_SEND   = 2'd0;
    localparam logic [1:0] MODE_RESP   = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    // Result kind codes.
    localparam logic [2:0] KIND_ISSUED    = 3'd0;
    localparam logic [2:0] KIND_MATCHED   = 3'd1;
    localparam logic [2:0] KIND_UNMATCHED = 3'd2;
    localparam logic [2:0] KIND_REISSUED  = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;

    // Configuration register indexes.
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_RETRY   = 1'b1;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_RESP,
        OP_TICK,
        OP_CANCEL
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  cmd;
        logic [15:0] rid;
        logic        link;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id;
        logic [7:0]  cmd;
        logic        last;
    } result_t;

endpackage

### src/rtrt_front.sv
// ----------------------------------------------------------------------------
// Request timeout retry tracker front end
// Accepts input items, classifies the mode and queues them for the engine.
// ----------------------------------------------------------------------------
module rtrt_front
    import rtrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  command_code,
    input  logic [15:0] lookup_id,
    input  logic        link_up,
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);

    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    item_t       new_item;
    logic        do_wr, do_rd;

    // Classify the incoming mode.
    always_comb
    begin
        new_item.cmd  = command_code;
        new_item.rid  = lookup_id;
        new_item.link = link_up;
        case (mode)
            MODE_SEND:   new_item.op = OP_SEND;
            MODE_RESP:   new_item.op = OP_RESP;
            MODE_TICK:   new_item.op = OP_TICK;
            MODE_CANCEL: new_item.op = OP_CANCEL;
            default:     new_item.op = OP_CANCEL;
        endcase
    end

    // Two-entry queue toward the engine.
    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign do_wr      = push && !full;
    assign do_rd      = item_valid && item_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        cnt_next    = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### src/rtrt_out_fifo.sv
// ----------------------------------------------------------------------------
// Request timeout retry tracker result queue
// Four-entry queue holding results until they are popped.
// ----------------------------------------------------------------------------
module rtrt_out_fifo
    import rtrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    wr_full,
    input  logic    pop,
    output logic    empty,
    output result_t rd_data
);

    result_t     q_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  cnt_reg, cnt_next;
    logic        do_wr, do_rd;

    assign wr_full = (cnt_reg == 3'd4);
    assign empty   = (cnt_reg == 3'd0);
    assign rd_data = q_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !wr_full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg + {2'b0, do_wr} - {2'b0, do_rd};
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + {1'b0, do_wr};
            rd_ptr_reg <= rd_ptr_reg + {1'b0, do_rd};
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/rtrt_engine.sv
// ----------------------------------------------------------------------------
// Request timeout retry tracker engine
// Holds the request table and walks it one slot per cycle for each item, unless a full result queue stalls it.
// ----------------------------------------------------------------------------
module rtrt_engine
    import rtrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    input  logic [15:0] timeout_ticks,
    input  logic [3:0]  retry_limit,
    output logic        out_wr,
    output result_t     out_data,
    input  logic        out_full
);

`include "request_timeout_retry_tracker_macros.svh"

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = (ID_BITS > 16) ? ID_BITS : 16;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    state_t               state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    item_t                item_reg;
    logic [31:0]          time_reg, time_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic                 hold_valid_reg, hold_valid_next;
    result_t              hold_reg, hold_next;
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [ID_BITS-1:0]   slot_id_reg    [TABLE_DEPTH];
    logic [7:0]           slot_cmd_reg   [TABLE_DEPTH];
    logic [31:0]          slot_dl_reg    [TABLE_DEPTH];
    logic [3:0]           slot_ret_reg   [TABLE_DEPTH];

    logic                 take, sv, id_match, expired, last_idx;
    logic [ID_BITS-1:0]   sid;
    logic [7:0]           scmd;
    logic [31:0]          sdl, age;
    logic [3:0]           sret;
    logic                 emit, done, stall;
    result_t              emit_res;
    logic                 wr_new, wr_reissue, clr_valid;

    // Current slot under the scan pointer.
    assign sid      = slot_id_reg[idx_reg];
    assign scmd     = slot_cmd_reg[idx_reg];
    assign sdl      = slot_dl_reg[idx_reg];
    assign sret     = slot_ret_reg[idx_reg];
    assign sv       = valid_reg[idx_reg];
    assign age      = time_reg - sdl;
    assign expired  = !age[31];
    assign last_idx = (idx_reg == LAST_IDX);
    assign id_match = (CW'(sid) == (CW'(item_reg.rid) & CW'({ID_BITS{1'b1}})));
    assign item_ready = (state_reg == ST_IDLE);
    assign take     = item_valid && item_ready;

    // Per-slot decision for the current operation.
    always_comb
    begin
        emit       = 1'b0;
        done       = 1'b0;
        wr_new     = 1'b0;
        wr_reissue = 1'b0;
        clr_valid  = 1'b0;
        emit_res   = '0;
        if (state_reg == ST_SCAN)
        begin
            case (item_reg.op)
                OP_SEND:
                begin
                    if (!sv)
                    begin
                        emit     = 1'b1;
                        done     = 1'b1;
                        wr_new   = 1'b1;
                        emit_res = '{KIND_ISSUED, 16'(CW'(next_id_reg)), item_reg.cmd, 1'b0};
                    end
                    else if (last_idx)
                    begin
                        emit     = 1'b1;
                        done     = 1'b1;
                        emit_res = '{KIND_FULL, 16'd0, item_reg.cmd, 1'b0};
                    end
                end
                OP_RESP:
                begin
                    if (sv && id_match)
                    begin
                        emit      = 1'b1;
                        done      = 1'b1;
                        clr_valid = 1'b1;
                        emit_res  = '{KIND_MATCHED, 16'(CW'(sid)), scmd, 1'b0};
                    end
                    else if (last_idx)
                    begin
                        emit     = 1'b1;
                        done     = 1'b1;
                        emit_res = '{KIND_UNMATCHED, item_reg.rid, 8'd0, 1'b0};
                    end
                end
                OP_CANCEL:
                begin
                    done      = (sv && id_match) || last_idx;
                    clr_valid = sv && id_match;
                end
                OP_TICK:
                begin
                    done = last_idx;
                    if (sv && expired)
                    begin
                        emit = 1'b1;
                        if ((sret != 4'd0) && item_reg.link)
                        begin
                            wr_reissue = 1'b1;
                            emit_res   = '{KIND_REISSUED, 16'(CW'(sid)), scmd, 1'b0};
                        end
                        else
                        begin
                            clr_valid = 1'b1;
                            emit_res  = '{KIND_TIMEOUT, 16'(CW'(sid)), scmd, 1'b0};
                        end
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    // A new result displaces the held one, which then cannot be the last.
    assign stall = emit && hold_valid_reg && out_full;

    // Sequencer and result holding stage.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        time_next       = time_reg;
        next_id_next    = next_id_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_wr          = 1'b0;
        out_data        = hold_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    if (item.op == OP_TICK)
                    begin
                        time_next = time_reg + 32'd1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (emit)
                    begin
                        out_wr          = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_next       = emit_res;
                    end
                    if (wr_new)
                    begin
                        next_id_next = next_id_reg + 1'b1;
                    end
                    if (done)
                    begin
                        state_next = (emit || hold_valid_reg) ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                out_data.last = 1'b1;
                if (!out_full)
                begin
                    out_wr          = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            time_reg       <= 32'd0;
            next_id_reg    <= '0;
            hold_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            time_reg       <= time_next;
            next_id_reg    <= next_id_next;
            hold_valid_reg <= hold_valid_next;
            if (!stall && (wr_new || clr_valid))
            begin
                valid_reg[idx_reg] <= wr_new;
            end
        end
    end

    // Payload registers and slot contents.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (take)
        begin
            item_reg <= item;
        end
        if (!stall && wr_new)
        begin
            slot_id_reg[idx_reg]  <= next_id_reg;
            slot_cmd_reg[idx_reg] <= item_reg.cmd;
            slot_dl_reg[idx_reg]  <= time_reg + 32'(timeout_ticks);
            slot_ret_reg[idx_reg] <= retry_limit;
        end
        if (!stall && wr_reissue)
        begin
            slot_ret_reg[idx_reg] <= sret - 4'd1;
            slot_dl_reg[idx_reg]  <= time_reg + 32'(timeout_ticks);
        end
    end

    // Checks on the engine's own sequencing.
    `RTRT_NEVER(a_no_push_full, out_wr && out_full, "result written into a full queue")
    `RTRT_ASSERT(a_flush_has_hold, (state_reg == ST_FLUSH) |-> hold_valid_reg, "flush without result")
    `RTRT_ASSERT(a_scan_starts_zero, take |=> (idx_reg == '0) && (state_reg == ST_SCAN), "scan start")
    `RTRT_ASSERT(a_one_emit_send, (state_reg == ST_SCAN) && (item_reg.op == OP_SEND) && emit |-> done, "send emitted twice")

endmodule

### src/request_timeout_retry_tracker.sv
// ----------------------------------------------------------------------------
// Request timeout retry tracker
// Outstanding request table with per-request deadline, retry and timeout.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue and are carried out one at a time by an engine
// that walks the request table one slot per cycle, pausing while a result waits
// on a full four-entry result queue. A send, response or cancel stops at the
// first free or matching slot; a tick always walks all TABLE_DEPTH slots.
// Configuration registers are index 0 timeout_ticks and index 1 retry_limit,
// always ready.
module request_timeout_retry_tracker
    import rtrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_BITS     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  command_code,
    input  logic [15:0] lookup_id,
    input  logic        link_up,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  result_kind,
    output logic [15:0] result_id,
    output logic [7:0]  result_command,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] timeout_reg;
    logic [3:0]  retry_reg;
    logic        item_valid, item_ready, out_wr, out_full;
    item_t       item;
    result_t     out_data, res;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd1000;
            retry_reg   <= 4'd3;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIMEOUT: timeout_reg <= cfg_data;
                REG_RETRY:   retry_reg   <= cfg_data[3:0];
                default:     timeout_reg <= timeout_reg;
            endcase
        end
    end

    rtrt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .command_code (command_code),
        .lookup_id    (lookup_id),
        .link_up      (link_up),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item)
    );

    rtrt_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .timeout_ticks (timeout_reg),
        .retry_limit   (retry_reg),
        .out_wr        (out_wr),
        .out_data      (out_data),
        .out_full      (out_full)
    );

    rtrt_out_fifo u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_data),
        .wr_full (out_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res)
    );

    assign result_kind    = res.kind;
    assign result_id      = res.id;
    assign result_command = res.cmd;
    assign last           = res.last;

endmodule
